// ===== hw/rtl/ogru_pkg.sv =====
// Shared constants, codes and types of the occupancy grid ray cast update block.
package ogru_pkg;

  localparam int GRID_W_DEF     = 64;
  localparam int GRID_H_DEF     = 64;
  localparam int COUNT_BITS_DEF = 16;

  localparam int IN_DATA_W  = 80;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    REQ_KEYFRAME = 2'd0,
    REQ_POINT    = 2'd1,
    REQ_CLEAR    = 2'd2,
    REQ_READ     = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CLS_OCCUPIED  = 2'd0,
    CLS_UNCERTAIN = 2'd1,
    CLS_FREE      = 2'd2
  } cell_class_t;

  typedef enum logic [2:0] {
    CFG_SCALE     = 3'd0,
    CFG_ORIGIN_X  = 3'd1,
    CFG_ORIGIN_Z  = 3'd2,
    CFG_NORM_X    = 3'd3,
    CFG_NORM_Z    = 3'd4,
    CFG_MIN_VISIT = 3'd5,
    CFG_FREE_LVL  = 3'd6,
    CFG_OCC_LVL   = 3'd7
  } cfg_idx_t;

  localparam logic [23:0] SCALE_RST     = 24'd196608;
  localparam logic [31:0] ORIGIN_X_RST  = 32'hFFE2_0000;
  localparam logic [31:0] ORIGIN_Z_RST  = 32'hFFF1_0000;
  localparam logic [16:0] NORM_X_RST    = 17'd64444;
  localparam logic [16:0] NORM_Z_RST    = 17'd64496;
  localparam logic [15:0] MIN_VISIT_RST = 16'd0;
  localparam logic [16:0] FREE_LVL_RST  = 17'd36045;
  localparam logic [16:0] OCC_LVL_RST   = 17'd32768;

  localparam logic [6:0] PCT_UNKNOWN = 7'd50;
  localparam logic [6:0] PCT_FULL    = 7'd100;

endpackage

// ===== hw/rtl/occupancy_grid_raycast_update.sv =====
// Top level of the occupancy grid ray cast update block.
//
//  channel  | direction | handshake              | payload
//  s_axis   | in        | s_axis_tvalid/tready   | tuser req_type, tdata coordinates and cell
//  m_axis   | out       | m_axis_tvalid/tready   | tdata result item
//  cfg      | in        | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// One item at a time; all quantizer and read-path multiplies go through one registered 33x26 multiplier.
// Keyframe: quantizes x and z to the ray origin cell. Point: quantizes, counts a hit and walks the ray from the origin.
// Read: fetches and classifies the counts; the percent divider runs only when visits exceed hits and the visit minimum.
// Clear item and reset: one pass over GRID_W*GRID_H cells, writing zero to both counts.
// A finished result holds in the output register until m_axis_tready.
module occupancy_grid_raycast_update #(
  parameter int GRID_W     = ogru_pkg::GRID_W_DEF,
  parameter int GRID_H     = ogru_pkg::GRID_H_DEF,
  parameter int COUNT_BITS = ogru_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // coord_x[31:0], coord_z[63:32], cell_row[69:64], cell_col[75:70], zero fill
  input  logic [ogru_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // req_type[1:0]
  input  logic [ogru_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // accepted[0], cell_class[2:1], occupancy_percent[9:3], visit_count[25:10],
  // hit_count[41:26], zero fill
  output logic [ogru_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ogru_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ogru_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ogru_pkg::*;

  localparam int DEPTH = GRID_W * GRID_H;
  localparam int AW    = $clog2(DEPTH);
  localparam int GMAX  = (GRID_W > GRID_H) ? GRID_W : GRID_H;
  localparam int CB    = $clog2(GMAX);
  localparam int EW    = CB + 3;
  localparam int EXT   = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam int NW    = COUNT_BITS + 7;
  localparam int PW    = 59;

  typedef enum logic [19:0] {
    ST_CLEAR    = 20'h00001,
    ST_IDLE     = 20'h00002,
    ST_QS       = 20'h00004,
    ST_QL       = 20'h00008,
    ST_QD       = 20'h00010,
    ST_QH       = 20'h00020,
    ST_QF       = 20'h00040,
    ST_HIT_RD   = 20'h00080,
    ST_HIT_WR   = 20'h00100,
    ST_WALK     = 20'h00200,
    ST_WALK_END = 20'h00400,
    ST_RD_REQ   = 20'h00800,
    ST_RD_WAIT  = 20'h01000,
    ST_MF       = 20'h02000,
    ST_MO       = 20'h04000,
    ST_MP       = 20'h08000,
    ST_MH       = 20'h10000,
    ST_MC       = 20'h20000,
    ST_DIV      = 20'h40000,
    ST_OUT      = 20'h80000
  } state_t;

  state_t state;

  // configuration registers
  logic [23:0]        scale;
  logic signed [31:0] edge_x, edge_z;
  logic [16:0]        norm_x, norm_z, free_lvl, occ_lvl;
  logic [15:0]        min_visit;

  // latched input item
  req_t               req;
  logic signed [31:0] cx, cz;
  logic [5:0]         rrow, rcol;

  // quantizer
  logic                 axis;
  logic signed [41:0]   dq;
  logic signed [PW-1:0] acc_lo;
  logic signed [PW-1:0] mprod;
  logic signed [32:0]   mul_a;
  logic signed [25:0]   mul_b;
  logic signed [63:0]   full;
  logic signed [31:0]   cellv;
  logic                 in_axis;
  logic [CB-1:0]        pcol, prow, ocol, orow;
  logic                 in_x, origin_valid;

  // walker
  logic [CB-1:0]        wx, wy, wx1;
  logic [CB-1:0]        dx, dy;
  logic signed [EW-1:0] err, err_n;
  logic                 steep, ystep_up;
  logic                 vis_pend;
  logic [AW-1:0]        pend_addr;
  logic [CB-1:0]        adx_c, ady_c;
  logic                 steep_c;

  // read path
  logic [COUNT_BITS-1:0]       v, h, den;
  logic signed [COUNT_BITS:0]  num;
  logic                        unk, rd_in, cmp_free;
  logic [NW-1:0]               rem, dsh;
  logic [2:0]                  dcnt;
  logic [6:0]                  quo;

  // clear sweep
  logic [AW-1:0] clr_addr;
  logic          clr_item;

  // result register
  logic              res_acc;
  cell_class_t       res_cls;
  logic [6:0]        res_pct;
  logic [15:0]       res_vis, res_hit;

  // RAM ports
  logic                  hit_we, vis_we;
  logic [AW-1:0]         hit_waddr, vis_waddr, hit_raddr, vis_raddr;
  logic [COUNT_BITS-1:0] hit_wdata, vis_wdata, hit_rdata, vis_rdata;
  logic [AW-1:0]         paddr, raddr, waddr_cur;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] x);
    sat_inc = (&x) ? x : x + COUNT_BITS'(1);
  endfunction

  function automatic logic [15:0] sat16(input logic [COUNT_BITS-1:0] x);
    logic [EXT-1:0] xe;
    xe = EXT'(x);
    sat16 = (xe > EXT'(16'hFFFF)) ? 16'hFFFF : xe[15:0];
  endfunction

  ogru_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_hit_ram (
    .clk(clk), .we(hit_we), .waddr(hit_waddr), .wdata(hit_wdata),
    .raddr(hit_raddr), .rdata(hit_rdata)
  );

  ogru_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_vis_ram (
    .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
    .raddr(vis_raddr), .rdata(vis_rdata)
  );

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = {6'd0, res_hit, res_vis, res_pct, res_cls, res_acc};

  assign paddr     = AW'(prow) * AW'(GRID_W) + AW'(pcol);
  assign raddr     = AW'(rrow) * AW'(GRID_W) + AW'(rcol);
  assign waddr_cur = steep ? (AW'(wx) * AW'(GRID_W) + AW'(wy))
                           : (AW'(wy) * AW'(GRID_W) + AW'(wx));

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_QS: begin
        mul_a = 33'(axis ? cz : cx);
        mul_b = $signed(26'(scale));
      end
      ST_QD: begin
        mul_a = $signed(33'(dq[23:0]));
        mul_b = $signed(26'(axis ? norm_z : norm_x));
      end
      ST_QH: begin
        mul_a = 33'($signed(dq[41:24]));
        mul_b = $signed(26'(axis ? norm_z : norm_x));
      end
      ST_MO: begin
        mul_a = $signed(33'(den));
        mul_b = $signed(26'(free_lvl));
      end
      ST_MP: begin
        mul_a = $signed(33'(den));
        mul_b = $signed(26'(occ_lvl));
      end
      ST_MH: begin
        mul_a = $signed(33'(h));
        mul_b = 26'sd100;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mprod <= PW'(mul_a * mul_b);
  end

  assign full    = (64'(mprod) <<< 24) + 64'(acc_lo);
  assign cellv   = full[63:32];
  assign in_axis = !cellv[31] &&
                   (cellv < (axis ? 32'(GRID_H) : 32'(GRID_W)));
  assign err_n   = err + EW'(dy);
  assign dsh     = NW'(v) << dcnt;

  // RAM port control
  always_comb begin
    hit_we    = 1'b0;
    hit_waddr = paddr;
    hit_wdata = sat_inc(hit_rdata);
    hit_raddr = (state == ST_RD_REQ) ? raddr : paddr;
    vis_we    = vis_pend;
    vis_waddr = pend_addr;
    vis_wdata = sat_inc(vis_rdata);
    vis_raddr = (state == ST_RD_REQ) ? raddr : waddr_cur;
    if (state == ST_CLEAR) begin
      hit_we    = 1'b1;
      hit_waddr = clr_addr;
      hit_wdata = '0;
      vis_we    = 1'b1;
      vis_waddr = clr_addr;
      vis_wdata = '0;
    end else if (state == ST_HIT_WR) begin
      hit_we = 1'b1;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      scale     <= SCALE_RST;
      edge_x    <= ORIGIN_X_RST;
      edge_z    <= ORIGIN_Z_RST;
      norm_x    <= NORM_X_RST;
      norm_z    <= NORM_Z_RST;
      min_visit <= MIN_VISIT_RST;
      free_lvl  <= FREE_LVL_RST;
      occ_lvl   <= OCC_LVL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SCALE:     scale     <= cfg_data[23:0];
        CFG_ORIGIN_X:  edge_x    <= cfg_data;
        CFG_ORIGIN_Z:  edge_z    <= cfg_data;
        CFG_NORM_X:    norm_x    <= cfg_data[16:0];
        CFG_NORM_Z:    norm_z    <= cfg_data[16:0];
        CFG_MIN_VISIT: min_visit <= cfg_data[15:0];
        CFG_FREE_LVL:  free_lvl  <= cfg_data[16:0];
        CFG_OCC_LVL:   occ_lvl   <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cx   <= s_axis_tdata[31:0];
        cz   <= s_axis_tdata[63:32];
        rrow <= s_axis_tdata[69:64];
        rcol <= s_axis_tdata[75:70];
      end
      ST_QL: begin
        dq <= 42'(mprod >>> 16) - 42'(axis ? edge_z : edge_x);
      end
      ST_QH: begin
        acc_lo <= mprod;
      end
      ST_QF: begin
        if (!axis) begin
          pcol <= cellv[CB-1:0];
        end else begin
          prow <= cellv[CB-1:0];
        end
      end
      ST_HIT_RD: begin
        // Bresenham setup: walk along the major axis from the lower end.
        if (steep_c) begin
          wx  <= (orow > prow) ? prow : orow;
          wy  <= (orow > prow) ? pcol : ocol;
          wx1 <= (orow > prow) ? orow : prow;
          dx  <= (orow > prow) ? orow - prow : prow - orow;
          ystep_up <= (orow > prow) ? (pcol < ocol) : (ocol < pcol);
        end else begin
          wx  <= (ocol > pcol) ? pcol : ocol;
          wy  <= (ocol > pcol) ? prow : orow;
          wx1 <= (ocol > pcol) ? ocol : pcol;
          dx  <= (ocol > pcol) ? ocol - pcol : pcol - ocol;
          ystep_up <= (ocol > pcol) ? (prow < orow) : (orow < prow);
        end
        dy    <= steep_c ? adx_c : ady_c;
        steep <= steep_c;
        err   <= '0;
      end
      ST_WALK: begin
        wx <= wx + CB'(1);
        if ((err_n <<< 1) >= $signed(EW'(dx))) begin
          wy  <= ystep_up ? wy + CB'(1) : wy - CB'(1);
          err <= err_n - EW'(dx);
        end else begin
          err <= err_n;
        end
      end
      ST_RD_WAIT: begin
        v <= rd_in ? vis_rdata : '0;
        h <= rd_in ? hit_rdata : '0;
      end
      ST_MF: begin
        unk <= EXT'(v) <= EXT'(min_visit);
        den <= (EXT'(v) <= EXT'(min_visit)) ? COUNT_BITS'(2) : v;
        num <= (EXT'(v) <= EXT'(min_visit)) ? (COUNT_BITS+1)'(1)
                 : $signed({1'b0, v}) - $signed({1'b0, h});
      end
      ST_MP: begin
        cmp_free <= (60'(num) <<< 16) >= 60'(mprod);
      end
      ST_MC: begin
        rem  <= mprod[NW-1:0];
        dcnt <= 3'd6;
        quo  <= '0;
      end
      ST_DIV: begin
        if (rem >= dsh) begin
          rem       <= rem - dsh;
          quo[dcnt] <= 1'b1;
        end
        dcnt <= dcnt - 3'd1;
      end
      default: ;
    endcase
    pend_addr <= waddr_cur;
  end

  assign adx_c   = (ocol > pcol) ? ocol - pcol : pcol - ocol;
  assign ady_c   = (orow > prow) ? orow - prow : prow - orow;
  assign steep_c = ady_c > adx_c;

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      clr_item     <= 1'b0;
      origin_valid <= 1'b0;
      ocol         <= '0;
      orow         <= '0;
      axis         <= 1'b0;
      in_x         <= 1'b0;
      vis_pend     <= 1'b0;
      rd_in        <= 1'b0;
      req          <= REQ_KEYFRAME;
      res_acc      <= 1'b0;
      res_cls      <= CLS_OCCUPIED;
      res_pct      <= '0;
      res_vis      <= '0;
      res_hit      <= '0;
    end else begin
      vis_pend <= (state == ST_WALK);
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            clr_addr <= '0;
            state    <= clr_item ? ST_OUT : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            req      <= req_t'(s_axis_tuser);
            res_acc  <= 1'b0;
            res_cls  <= CLS_OCCUPIED;
            res_pct  <= '0;
            res_vis  <= '0;
            res_hit  <= '0;
            axis     <= 1'b0;
            clr_item <= 1'b1;
            case (req_t'(s_axis_tuser))
              REQ_CLEAR: state <= ST_CLEAR;
              REQ_READ:  state <= ST_RD_REQ;
              default:   state <= ST_QS;
            endcase
          end
        end
        ST_QS: state <= ST_QL;
        ST_QL: state <= ST_QD;
        ST_QD: state <= ST_QH;
        ST_QH: state <= ST_QF;
        ST_QF: begin
          if (!axis) begin
            in_x  <= in_axis;
            axis  <= 1'b1;
            state <= ST_QS;
          end else if (req == REQ_KEYFRAME) begin
            origin_valid <= in_x && in_axis;
            if (in_x && in_axis) begin
              ocol <= pcol;
              orow <= cellv[CB-1:0];
            end
            res_acc <= in_x && in_axis;
            state   <= ST_OUT;
          end else if (in_x && in_axis && origin_valid) begin
            state <= ST_HIT_RD;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_HIT_RD: state <= ST_HIT_WR;
        ST_HIT_WR: state <= ST_WALK;
        ST_WALK: begin
          if (wx == wx1) begin
            state <= ST_WALK_END;
          end
        end
        ST_WALK_END: begin
          res_acc <= 1'b1;
          state   <= ST_OUT;
        end
        ST_RD_REQ: begin
          rd_in <= (32'(rrow) < 32'(GRID_H)) && (32'(rcol) < 32'(GRID_W));
          state <= ST_RD_WAIT;
        end
        ST_RD_WAIT: state <= ST_MF;
        ST_MF: begin
          res_vis <= sat16(v);
          res_hit <= sat16(h);
          state   <= ST_MO;
        end
        ST_MO: state <= ST_MP;
        ST_MP: state <= ST_MH;
        ST_MH: begin
          if (cmp_free) begin
            res_cls <= CLS_FREE;
          end else if ((60'(num) <<< 16) >= 60'(mprod)) begin
            res_cls <= CLS_UNCERTAIN;
          end else begin
            res_cls <= CLS_OCCUPIED;
          end
          state <= ST_MC;
        end
        ST_MC: begin
          if (unk) begin
            res_pct <= PCT_UNKNOWN;
            state   <= ST_OUT;
          end else if (h >= v) begin
            res_pct <= PCT_FULL;
            state   <= ST_OUT;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (dcnt == 3'd0) begin
            res_pct <= quo | ((rem >= dsh) ? 7'd1 : 7'd0);
            state   <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input taken while a result is pending");

  a_pend_after_walk: assert property (@(posedge clk) disable iff (rst)
    vis_pend |-> $past(state == ST_WALK))
    else $error("visit write without a walk step");

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !s_axis_tready)
    else $error("input ready during clearing pass");

  a_read_not_accepted: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (req == REQ_READ || req == REQ_CLEAR)) |-> !res_acc)
    else $error("read or clear result flagged accepted");
`endif

endmodule

// ===== hw/rtl/ogru_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module ogru_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/sv/occupancy_grid_raycast_update_tb.sv =====
// Self-checking testbench of the occupancy grid ray cast update block.
module occupancy_grid_raycast_update_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ogru_pkg::*;

  localparam int GW = 64;
  localparam int GH = 64;
  localparam int CELLS = GW * GH;

  typedef struct {
    req_t        op;
    logic [31:0] x;
    logic [31:0] z;
    logic [5:0]  row;
    logic [5:0]  col;
  } grid_req_t;

  typedef struct {
    logic        acc;
    cell_class_t cls;
    logic [6:0]  pct;
    logic [15:0] visits;
    logic [15:0] hits;
  } grid_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [IN_USER_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  occupancy_grid_raycast_update dut (.*);

  always #1 clk = ~clk;

  // Mirror of the block's state and registers.
  longint scale, edge_x, edge_z, norm_x, norm_z, min_vis, free_lvl, occ_lvl;
  logic [15:0] hit_tab [CELLS];
  logic [15:0] visit_tab [CELLS];
  int ray_col, ray_row;
  bit ray_ok;

  grid_req_t send_q[$];
  grid_res_t result_q[$];
  int errors = 0;

  function automatic void clear_counts();
    for (int i = 0; i < CELLS; i++) begin
      hit_tab[i] = '0;
      visit_tab[i] = '0;
    end
  endfunction

  function automatic void write_reg(cfg_idx_t idx, logic [31:0] d);
    case (idx)
      CFG_SCALE:     scale = d[23:0];
      CFG_ORIGIN_X:  edge_x = longint'($signed(d));
      CFG_ORIGIN_Z:  edge_z = longint'($signed(d));
      CFG_NORM_X:    norm_x = d[16:0];
      CFG_NORM_Z:    norm_z = d[16:0];
      CFG_MIN_VISIT: min_vis = d[15:0];
      CFG_FREE_LVL:  free_lvl = d[16:0];
      CFG_OCC_LVL:   occ_lvl = d[16:0];
      default: ;
    endcase
  endfunction

  // Arithmetic shifts of signed values floor toward minus infinity.
  function automatic longint grid_index(logic [31:0] c, longint edge_q, longint norm);
    longint s;
    s = (longint'($signed(c)) * scale) >>> 16;
    return ((s - edge_q) * norm) >>> 32;
  endfunction

  function automatic void visit_cell(int c, int r);
    if (c >= 0 && c < GW && r >= 0 && r < GH && visit_tab[r*GW+c] != 16'hFFFF)
      visit_tab[r*GW+c]++;
  endfunction

  function automatic void trace_ray(int x0, int y0, int x1, int y1);
    int t, dx, dy, err, y, ystep;
    bit steep;
    steep = ((y1 > y0) ? y1 - y0 : y0 - y1) > ((x1 > x0) ? x1 - x0 : x0 - x1);
    if (steep) begin
      t = x0; x0 = y0; y0 = t;
      t = x1; x1 = y1; y1 = t;
    end
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
      t = y0; y0 = y1; y1 = t;
    end
    dx = x1 - x0;
    dy = (y1 > y0) ? y1 - y0 : y0 - y1;
    y = y0;
    ystep = (y0 < y1) ? 1 : -1;
    err = 0;
    for (int x = x0; x <= x1; x++) begin
      if (steep) visit_cell(y, x);
      else visit_cell(x, y);
      err += dy;
      if (2 * err >= dx) begin
        y += ystep;
        err -= dx;
      end
    end
  endfunction

  function automatic grid_res_t update_grid(grid_req_t rq);
    grid_res_t rs;
    longint c, r, num, den, v, h;
    bit in_grid;
    rs = '{1'b0, CLS_OCCUPIED, 7'd0, 16'd0, 16'd0};
    case (rq.op)
      REQ_KEYFRAME, REQ_POINT: begin
        c = grid_index(rq.x, edge_x, norm_x);
        r = grid_index(rq.z, edge_z, norm_z);
        in_grid = c >= 0 && c < GW && r >= 0 && r < GH;
        if (rq.op == REQ_KEYFRAME) begin
          ray_ok = in_grid;
          if (in_grid) begin
            ray_col = int'(c);
            ray_row = int'(r);
            rs.acc = 1'b1;
          end
        end else if (in_grid && ray_ok) begin
          if (hit_tab[r*GW+c] != 16'hFFFF) hit_tab[r*GW+c]++;
          trace_ray(ray_col, ray_row, int'(c), int'(r));
          rs.acc = 1'b1;
        end
      end
      REQ_CLEAR: clear_counts();
      default: begin
        v = visit_tab[rq.row*GW+rq.col];
        h = hit_tab[rq.row*GW+rq.col];
        if (v <= min_vis) begin
          num = 1;
          den = 2;
          rs.pct = PCT_UNKNOWN;
        end else begin
          num = v - h;
          den = v;
          rs.pct = ((h * 100) / v > 100) ? PCT_FULL : 7'((h * 100) / v);
        end
        if (num * 65536 >= free_lvl * den) rs.cls = CLS_FREE;
        else if (num * 65536 >= occ_lvl * den) rs.cls = CLS_UNCERTAIN;
        else rs.cls = CLS_OCCUPIED;
        rs.visits = v[15:0];
        rs.hits = h[15:0];
      end
    endcase
    return rs;
  endfunction

  // Sender: one item at a time from send_q, random gap after each item.
  int send_gap = 0;
  bit send_burst = 1'b0;
  always @(posedge clk) begin
    grid_req_t rq;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        rq.op = req_t'(s_axis_tuser);
        rq.x = s_axis_tdata[31:0];
        rq.z = s_axis_tdata[63:32];
        rq.row = s_axis_tdata[69:64];
        rq.col = s_axis_tdata[75:70];
        result_q.push_back(update_grid(rq));
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (send_q.size() > 0) begin
        rq = send_q.pop_front();
        s_axis_tuser <= rq.op;
        s_axis_tdata <= {4'd0, rq.col, rq.row, rq.z, rq.x};
        s_axis_tvalid <= 1'b1;
        if ($urandom_range(0, 79) == 0) send_burst = !send_burst;
        send_gap <= send_burst ? 0 : $urandom_range(0, 18);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: checks each result item and stalls at random after it.
  int recv_stall = 0;
  always @(posedge clk) begin
    grid_res_t want;
    int stall;
    stall = recv_stall;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (result_q.size() == 0) begin
        $error("result item with no expectation pending");
        errors++;
      end else begin
        want = result_q.pop_front();
        if (m_axis_tdata[0] !== want.acc) begin
          $error("accepted: expected %0d, got %0d", want.acc, m_axis_tdata[0]);
          errors++;
        end
        if (m_axis_tdata[2:1] !== want.cls) begin
          $error("cell_class: expected %0d, got %0d", want.cls, m_axis_tdata[2:1]);
          errors++;
        end
        if (m_axis_tdata[9:3] !== want.pct) begin
          $error("occupancy_percent: expected %0d, got %0d", want.pct, m_axis_tdata[9:3]);
          errors++;
        end
        if (m_axis_tdata[25:10] !== want.visits) begin
          $error("visit_count: expected %0d, got %0d", want.visits, m_axis_tdata[25:10]);
          errors++;
        end
        if (m_axis_tdata[41:26] !== want.hits) begin
          $error("hit_count: expected %0d, got %0d", want.hits, m_axis_tdata[41:26]);
          errors++;
        end
      end
      stall = send_burst ? 0 : $urandom_range(0, 18);
    end else if (stall > 0) begin
      stall--;
    end
    recv_stall <= stall;
    m_axis_tready <= !rst && stall == 0;
  end

  // Position in Q16.16 metres, mostly within [lo, hi], now and then any value.
  function automatic logic [31:0] pick_coord(int lo, int hi);
    if ($urandom_range(0, 9) == 0) return $urandom;
    return 32'(lo * 65536 + int'($urandom_range(0, (hi - lo) * 65536)));
  endfunction

  function automatic void add_item(req_t op, logic [31:0] x, logic [31:0] z,
                                   logic [5:0] row, logic [5:0] col);
    send_q.push_back('{op, x, z, row, col});
  endfunction

  // Random mix of items: mostly points and reads, with occasional keyframes and clears.
  task automatic queue_random(int n, int xlo, int xhi, int zlo, int zhi);
    int k;
    req_t op;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      op = (k < 10) ? REQ_KEYFRAME : (k < 62) ? REQ_POINT : (k < 98) ? REQ_READ : REQ_CLEAR;
      add_item(op, pick_coord(xlo, xhi), pick_coord(zlo, zhi), 6'($urandom), 6'($urandom));
    end
  endtask

  task automatic set_reg(cfg_idx_t idx, logic [31:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    write_reg(idx, d);
    cfg_valid <= 1'b0;
  endtask

  // Lets the block drain and sit idle before the registers change.
  task automatic drain();
    wait (send_q.size() == 0 && !s_axis_tvalid && result_q.size() == 0);
    repeat (4200) @(posedge clk);
  endtask

  initial begin
    scale = SCALE_RST;
    edge_x = longint'($signed(ORIGIN_X_RST));
    edge_z = longint'($signed(ORIGIN_Z_RST));
    norm_x = NORM_X_RST;
    norm_z = NORM_Z_RST;
    min_vis = MIN_VISIT_RST;
    free_lvl = FREE_LVL_RST;
    occ_lvl = OCC_LVL_RST;
    clear_counts();
    ray_col = 0;
    ray_row = 0;
    ray_ok = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset settings (x -10..11.6 m, z -5..16 m inside).
    add_item(REQ_READ, 32'd0, 32'd0, 6'd0, 6'd0);
    add_item(REQ_POINT, 32'd0, 32'd0, 6'd0, 6'd0);
    add_item(REQ_KEYFRAME, 32'h7FFF_FFFF, 32'h8000_0000, 6'h3F, 6'h3F);
    add_item(REQ_POINT, 32'd0, 32'd0, 6'd0, 6'd0);
    add_item(REQ_KEYFRAME, 32'd0, 32'd0, 6'd0, 6'd0);
    add_item(REQ_POINT, 32'hFFF6_0000, 32'hFFFB_0000, 6'd0, 6'd0);
    add_item(REQ_POINT, 32'h000B_5000, 32'h0010_4000, 6'd0, 6'd0);
    add_item(REQ_POINT, 32'h000B_5000, 32'hFFFB_0000, 6'd0, 6'd0);
    add_item(REQ_POINT, 32'h8000_0000, 32'h7FFF_FFFF, 6'd0, 6'd0);
    add_item(REQ_POINT, 32'h0001_0000, 32'h0010_0000, 6'd0, 6'd0);
    add_item(REQ_KEYFRAME, 32'hFFF6_0000, 32'h0010_4000, 6'd0, 6'd0);
    add_item(REQ_POINT, 32'h000B_5000, 32'hFFFB_0000, 6'd0, 6'd0);
    add_item(REQ_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0, 6'd0);
    add_item(REQ_READ, 32'd0, 32'd0, 6'h3F, 6'h3F);
    add_item(REQ_READ, 32'd0, 32'd0, 6'd20, 6'd30);
    add_item(REQ_READ, 32'd0, 32'd0, 6'd16, 6'd30);
    add_item(REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F, 6'h3F);
    add_item(REQ_READ, 32'd0, 32'd0, 6'd20, 6'd30);
    add_item(REQ_POINT, 32'h0001_0000, 32'h0002_0000, 6'd0, 6'd0);
    add_item(REQ_READ, 32'd0, 32'd0, 6'd20, 6'd30);
    queue_random(250, -11, 12, -6, 17);
    drain();
    queue_random(250, -11, 12, -6, 17);
    drain();

    // Identity mapping: a metre is one cell.
    set_reg(CFG_SCALE, 32'd65536);
    set_reg(CFG_ORIGIN_X, 32'd0);
    set_reg(CFG_ORIGIN_Z, 32'd0);
    set_reg(CFG_NORM_X, 32'd65536);
    set_reg(CFG_NORM_Z, 32'd65536);
    queue_random(450, -2, 66, -2, 66);
    drain();

    // Register extremes.
    set_reg(CFG_SCALE, 32'hFF_FFFF);
    set_reg(CFG_ORIGIN_X, 32'h8000_0000);
    set_reg(CFG_ORIGIN_Z, 32'h7FFF_FFFF);
    set_reg(CFG_NORM_X, 32'd0);
    set_reg(CFG_MIN_VISIT, 32'hFFFF);
    set_reg(CFG_FREE_LVL, 32'd0);
    set_reg(CFG_OCC_LVL, 32'd65536);
    queue_random(150, 126, 130, 126, 130);
    drain();

    set_reg(CFG_SCALE, 32'd131072);
    set_reg(CFG_ORIGIN_X, 32'hFFF6_0000);
    set_reg(CFG_ORIGIN_Z, 32'd0);
    set_reg(CFG_NORM_X, 32'd52429);
    set_reg(CFG_MIN_VISIT, 32'd3);
    set_reg(CFG_FREE_LVL, 32'd45000);
    set_reg(CFG_OCC_LVL, 32'd20000);
    queue_random(300, -7, 37, -2, 33);
    drain();

    set_reg(CFG_SCALE, SCALE_RST);
    set_reg(CFG_ORIGIN_X, ORIGIN_X_RST);
    set_reg(CFG_ORIGIN_Z, ORIGIN_Z_RST);
    set_reg(CFG_NORM_X, NORM_X_RST);
    set_reg(CFG_NORM_Z, NORM_Z_RST);
    set_reg(CFG_MIN_VISIT, 32'd1);
    set_reg(CFG_FREE_LVL, 32'd65536);
    set_reg(CFG_OCC_LVL, 32'd0);
    queue_random(280, -11, 12, -6, 17);
    drain();

    if (errors == 0 && result_q.size() == 0) begin
      $display("occupancy_grid_raycast_update regression: pass");
    end else begin
      $display("occupancy_grid_raycast_update regression: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("occupancy_grid_raycast_update regression: fail");
    $finish;
  end

endmodule
